### hw/rtl/hrl_pkg.sv
package hrl_pkg;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_COUNT,
      PH_ADDR,
      PH_TYPE,
      PH_DATA,
      PH_EXTRA,
      PH_CHK
   } phase_type;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_EOF   = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [2:0] ERR_START = 3'd0;
   localparam logic [2:0] ERR_DIGIT = 3'd1;
   localparam logic [2:0] ERR_TYPE  = 3'd2;
   localparam logic [2:0] ERR_ADDR  = 3'd3;
   localparam logic [2:0] ERR_SUM   = 3'd4;

   localparam logic [2:0] REC_DATA = 3'd0;
   localparam logic [2:0] REC_EOF  = 3'd1;
   localparam logic [2:0] REC_ESA  = 3'd2;
   localparam logic [2:0] REC_SSA  = 3'd3;
   localparam logic [2:0] REC_ELA  = 3'd4;
   localparam logic [2:0] REC_SLA  = 3'd5;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SUB   = 8'd26;
   localparam logic [7:0] CH_COLON = 8'h3A;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } nibble_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] char_in;
   } char_stage_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] write_address;
      logic [7:0]  write_data;
      logic [31:0] start_address;
      logic [2:0]  error_code;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type payload;
   } result_type;

   function automatic nibble_type hex_nibble(input logic [7:0] c);
      nibble_type n;
      n.ok  = 1'b0;
      n.val = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         n.ok = 1'b1;
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         n.ok  = 1'b1;
         n.val = c[3:0] + 4'd9;
      end
      return n;
   endfunction

endpackage

### hw/rtl/hrl_chan_if.sv
interface hrl_char_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

interface hrl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] write_address;
   logic [7:0]  write_data;
   logic [31:0] start_address;
   logic [2:0]  error_code;

   modport source (output valid, output result_kind, output write_address,
                   output write_data, output start_address, output error_code,
                   input ready);
   modport sink (input valid, input result_kind, input write_address,
                 input write_data, input start_address, input error_code,
                 output ready);
endinterface

### hw/rtl/hrl_in_reg.sv
module hrl_in_reg (
   input  logic                    clock,
   input  logic                    reset,
   hrl_char_if.sink                req_chan,
   input  logic                    take,
   output hrl_pkg::char_stage_type stage
);
   import hrl_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] char_ff;
   logic       load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= req_chan.char_in;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.char_in = char_ff;
endmodule

### hw/rtl/hrl_parser.sv
module hrl_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  hrl_pkg::char_stage_type stage,
   input  logic                    free,
   output hrl_pkg::result_type     result
);
   import hrl_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  digit_ff, digit_in;
   logic [31:0] field_ff, field_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] raddr_ff, raddr_in;
   logic [2:0]  rtype_ff, rtype_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  index_ff, index_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] start_ff, start_in;
   logic        stopped_ff, stopped_in;

   nibble_type  nib;
   logic        step;
   logic [31:0] field_next;
   logic [3:0]  digit_next;
   logic [7:0]  sum_next;
   logic [3:0]  needed;
   logic [7:0]  index_next;
   logic [2:0]  type_next;

   assign step       = stage.valid && free;
   assign nib        = hex_nibble(stage.char_in);
   assign field_next = {field_ff[27:0], nib.val};
   assign digit_next = digit_ff + 4'd1;
   assign sum_next   = digit_next[0] ? sum_ff : sum_ff + field_next[7:0];
   assign index_next = index_ff + 8'd1;
   assign type_next  = field_next[2:0];

   always_comb begin
      unique case (phase_ff)
         PH_ADDR:  needed = 4'd4;
         PH_EXTRA: needed = (rtype_ff == REC_ESA || rtype_ff == REC_ELA) ? 4'd4 : 4'd8;
         default:  needed = 4'd2;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      digit_in   = digit_ff;
      field_in   = field_ff;
      count_in   = count_ff;
      raddr_in   = raddr_ff;
      rtype_in   = rtype_ff;
      sum_in     = sum_ff;
      index_in   = index_ff;
      base_in    = base_ff;
      start_in   = start_ff;
      stopped_in = stopped_ff;
      result     = '0;

      if (step && !stopped_ff) begin
         if (phase_ff == PH_WAIT) begin
            priority if (stage.char_in == CH_CR || stage.char_in == CH_LF ||
                         stage.char_in == CH_SUB) begin
               phase_in = PH_WAIT;
            end else if (stage.char_in == CH_NUL) begin
               stopped_in = 1'b1;
            end else if (stage.char_in != CH_COLON) begin
               stopped_in                 = 1'b1;
               result.valid               = 1'b1;
               result.payload.result_kind = KIND_ERROR;
               result.payload.error_code  = ERR_START;
            end else begin
               phase_in = PH_COUNT;
               digit_in = '0;
               field_in = '0;
               sum_in   = '0;
               index_in = '0;
            end
         end else if (!nib.ok) begin
            stopped_in                 = 1'b1;
            result.valid               = 1'b1;
            result.payload.result_kind = KIND_ERROR;
            result.payload.error_code  = ERR_DIGIT;
         end else if (digit_next < needed) begin
            field_in = field_next;
            digit_in = digit_next;
            sum_in   = sum_next;
         end else begin
            field_in = '0;
            digit_in = '0;
            sum_in   = sum_next;
            unique case (phase_ff)
               PH_COUNT: begin
                  count_in = field_next[7:0];
                  phase_in = PH_ADDR;
               end
               PH_ADDR: begin
                  raddr_in = field_next[15:0];
                  phase_in = PH_TYPE;
               end
               PH_TYPE: begin
                  rtype_in = type_next;
                  if (field_next[7:0] > {5'd0, REC_SLA}) begin
                     stopped_in                 = 1'b1;
                     result.valid               = 1'b1;
                     result.payload.result_kind = KIND_ERROR;
                     result.payload.error_code  = ERR_TYPE;
                  end else if ((type_next == REC_ESA || type_next == REC_SSA ||
                                type_next == REC_SLA) && raddr_ff != 16'd0) begin
                     stopped_in                 = 1'b1;
                     result.valid               = 1'b1;
                     result.payload.result_kind = KIND_ERROR;
                     result.payload.error_code  = ERR_ADDR;
                  end else if (type_next == REC_DATA) begin
                     phase_in = (count_ff != 8'd0) ? PH_DATA : PH_CHK;
                  end else if (type_next == REC_EOF) begin
                     start_in = {16'd0, raddr_ff};
                     phase_in = PH_CHK;
                  end else begin
                     phase_in = PH_EXTRA;
                  end
               end
               PH_DATA: begin
                  index_in                     = index_next;
                  if (index_next == count_ff) begin
                     phase_in = PH_CHK;
                  end
                  result.valid                 = 1'b1;
                  result.payload.result_kind   = KIND_DATA;
                  result.payload.write_address = base_ff + {16'd0, raddr_ff} +
                                                 {24'd0, index_ff};
                  result.payload.write_data    = field_next[7:0];
               end
               PH_EXTRA: begin
                  start_in = field_next;
                  phase_in = PH_CHK;
               end
               default: begin
                  if (sum_next != 8'd0) begin
                     stopped_in                 = 1'b1;
                     result.valid               = 1'b1;
                     result.payload.result_kind = KIND_ERROR;
                     result.payload.error_code  = ERR_SUM;
                  end else begin
                     phase_in = PH_WAIT;
                     priority case (rtype_ff)
                        REC_EOF: begin
                           stopped_in                   = 1'b1;
                           result.valid                 = 1'b1;
                           result.payload.result_kind   = KIND_EOF;
                           result.payload.start_address = start_ff;
                        end
                        REC_ESA: base_in = {12'd0, start_ff[15:0], 4'd0};
                        REC_ELA: base_in = {start_ff[15:0], 16'd0};
                        REC_SSA, REC_SLA: begin
                           result.valid                 = 1'b1;
                           result.payload.result_kind   = KIND_START;
                           result.payload.start_address = start_ff;
                        end
                        default: phase_in = PH_WAIT;
                     endcase
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT;
         digit_ff   <= '0;
         field_ff   <= '0;
         count_ff   <= '0;
         raddr_ff   <= '0;
         rtype_ff   <= '0;
         sum_ff     <= '0;
         index_ff   <= '0;
         base_ff    <= '0;
         start_ff   <= '0;
         stopped_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         digit_ff   <= digit_in;
         field_ff   <= field_in;
         count_ff   <= count_in;
         raddr_ff   <= raddr_in;
         rtype_ff   <= rtype_in;
         sum_ff     <= sum_in;
         index_ff   <= index_in;
         base_ff    <= base_in;
         start_ff   <= start_in;
         stopped_ff <= stopped_in;
      end
   end
endmodule

### hw/rtl/hrl_out_reg.sv
module hrl_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  hrl_pkg::result_type result,
   output logic                free,
   hrl_rsp_if.source           rsp_chan
);
   import hrl_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign free     = !valid_ff || rsp_chan.ready;
   assign valid_in = free ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && result.valid) begin
         data_ff <= result.payload;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.result_kind   = data_ff.result_kind;
   assign rsp_chan.write_address = data_ff.write_address;
   assign rsp_chan.write_data    = data_ff.write_data;
   assign rsp_chan.start_address = data_ff.start_address;
   assign rsp_chan.error_code    = data_ff.error_code;
endmodule

### hw/rtl/hex_record_loader.sv
// Intel HEX record loader. Characters of a hex file enter on req_chan, one per item.
// Each data byte of a data record leaves on rsp_chan as a write item with its full
// address as soon as its second digit arrives, before the checksum is checked.
// Start address records, the end-of-file record and errors also give one item each.
// A character passes through an input register, is decoded by a single pass of
// logic against the parser state, and its result lands in an output register.
// A result is loaded into the output register, which drives rsp_chan, when its
// character leaves the input register. A character is taken every cycle unless
// rsp_chan stalls; the path is one nibble shift, a byte add and the address add.
// When rsp_chan stalls, the output register holds its item and the input register
// takes one more only if empty, then req_chan.ready is low until the result moves.
// Every character, whether or not it gives a result, waits in the input register
// while a stalled result sits in the output register.
// Synchronous reset clears both registers and returns the parser to waiting for a
// record start with a zero extended address base.
// After an error, an end-of-file record or a NUL between records, all further
// characters are taken and ignored until reset.
module hex_record_loader (
   input logic       clock,
   input logic       reset,
   hrl_char_if.sink  req_chan,
   hrl_rsp_if.source rsp_chan
);
   import hrl_pkg::*;

   char_stage_type stage;
   result_type     result;
   logic           free;

   hrl_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (free),
      .stage    (stage)
   );

   hrl_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .free   (free),
      .result (result)
   );

   hrl_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .free     (free),
      .rsp_chan (rsp_chan)
   );

   a_result_needs_char: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (stage.valid && free))
      else $error("result produced without a character");

   a_quiet_after_error: assert property (@(posedge clock) disable iff (reset)
      (result.valid && free && result.payload.result_kind == KIND_ERROR) |=> !result.valid)
      else $error("result produced after an error");

   a_quiet_after_eof: assert property (@(posedge clock) disable iff (reset)
      (result.valid && free && result.payload.result_kind == KIND_EOF) |=> !result.valid)
      else $error("result produced after end of file");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> stage.valid)
      else $error("accepted character missing from input register");

   a_reset_empties_output: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("output valid after reset");
endmodule

### tb/hex_record_loader_checker.sv
`timescale 1ns / 1ps

module hex_record_loader_checker (
   input  logic clock,
   input  logic reset,
   hrl_char_if  req_mon,
   hrl_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);
   import hrl_pkg::*;

   phase_type   parse_state;
   logic [3:0]  digit_cnt;
   logic [31:0] field_acc;
   logic [7:0]  rec_count;
   logic [15:0] rec_addr;
   logic [7:0]  rec_type;
   logic [7:0]  byte_sum;
   logic [7:0]  byte_idx;
   logic [31:0] ext_base;
   logic [31:0] start_hold;
   logic        halted;

   rsp_type decoded_results[$];
   rsp_type seen;
   rsp_type oldest;

   function automatic void clear_decoder();
      parse_state = PH_WAIT;
      digit_cnt   = 4'd0;
      field_acc   = 32'd0;
      rec_count   = 8'd0;
      rec_addr    = 16'd0;
      rec_type    = 8'd0;
      byte_sum    = 8'd0;
      byte_idx    = 8'd0;
      ext_base    = 32'd0;
      start_hold  = 32'd0;
      halted      = 1'b0;
   endfunction

   function automatic void push_result(input logic [1:0] kind, input logic [31:0] waddr,
                                       input logic [7:0] wdata, input logic [31:0] start,
                                       input logic [2:0] code);
      rsp_type r;
      r.result_kind   = kind;
      r.write_address = waddr;
      r.write_data    = wdata;
      r.start_address = start;
      r.error_code    = code;
      decoded_results.push_back(r);
   endfunction

   function automatic void push_error(input logic [2:0] code);
      halted = 1'b1;
      push_result(KIND_ERROR, 32'd0, 8'd0, 32'd0, code);
   endfunction

   function automatic void decode_char(input logic [7:0] c);
      logic        is_hex;
      logic [7:0]  diff;
      logic [3:0]  need;
      logic [31:0] value;
      logic [31:0] waddr;
      if (halted) return;
      if (parse_state == PH_WAIT) begin
         if (c == CH_CR || c == CH_LF || c == CH_SUB) return;
         if (c == CH_NUL) begin
            halted = 1'b1;
            return;
         end
         if (c != CH_COLON) begin
            push_error(ERR_START);
            return;
         end
         parse_state = PH_COUNT;
         digit_cnt   = 4'd0;
         field_acc   = 32'd0;
         byte_sum    = 8'd0;
         byte_idx    = 8'd0;
         return;
      end

      is_hex = 1'b1;
      if (c >= "0" && c <= "9") begin
         diff = c - "0";
      end else if (c >= "A" && c <= "F") begin
         diff = c - "A" + 8'd10;
      end else if (c >= "a" && c <= "f") begin
         diff = c - "a" + 8'd10;
      end else begin
         is_hex = 1'b0;
         diff   = 8'd0;
      end
      if (!is_hex) begin
         push_error(ERR_DIGIT);
         return;
      end
      field_acc = {field_acc[27:0], diff[3:0]};
      digit_cnt = digit_cnt + 4'd1;
      if (!digit_cnt[0]) byte_sum = byte_sum + field_acc[7:0];
      case (parse_state)
         PH_ADDR:  need = 4'd4;
         PH_EXTRA: need = (rec_type == REC_ESA || rec_type == REC_ELA) ? 4'd4 : 4'd8;
         default:  need = 4'd2;
      endcase
      if (digit_cnt < need) return;

      value     = field_acc;
      digit_cnt = 4'd0;
      field_acc = 32'd0;
      case (parse_state)
         PH_COUNT: begin
            rec_count   = value[7:0];
            parse_state = PH_ADDR;
         end
         PH_ADDR: begin
            rec_addr    = value[15:0];
            parse_state = PH_TYPE;
         end
         PH_TYPE: begin
            rec_type = value[7:0];
            if (rec_type > REC_SLA) begin
               push_error(ERR_TYPE);
            end else if ((rec_type == REC_ESA || rec_type == REC_SSA ||
                          rec_type == REC_SLA) && rec_addr != 16'd0) begin
               push_error(ERR_ADDR);
            end else if (rec_type == REC_DATA) begin
               parse_state = (rec_count != 8'd0) ? PH_DATA : PH_CHK;
            end else if (rec_type == REC_EOF) begin
               start_hold  = {16'd0, rec_addr};
               parse_state = PH_CHK;
            end else begin
               parse_state = PH_EXTRA;
            end
         end
         PH_DATA: begin
            waddr    = ext_base + {16'd0, rec_addr} + {24'd0, byte_idx};
            byte_idx = byte_idx + 8'd1;
            if (byte_idx == rec_count) parse_state = PH_CHK;
            push_result(KIND_DATA, waddr, value[7:0], 32'd0, 3'd0);
         end
         PH_EXTRA: begin
            start_hold  = value;
            parse_state = PH_CHK;
         end
         default: begin
            if (byte_sum != 8'd0) begin
               push_error(ERR_SUM);
            end else begin
               parse_state = PH_WAIT;
               case (rec_type)
                  REC_EOF: begin
                     halted = 1'b1;
                     push_result(KIND_EOF, 32'd0, 8'd0, start_hold, 3'd0);
                  end
                  REC_ESA: ext_base = {12'd0, start_hold[15:0], 4'd0};
                  REC_ELA: ext_base = {start_hold[15:0], 16'd0};
                  REC_SSA, REC_SLA: push_result(KIND_START, 32'd0, 8'd0, start_hold, 3'd0);
                  default: ;
               endcase
            end
         end
      endcase
   endfunction

   function automatic void flag_result(input string why, input rsp_type want,
                                       input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected kind %0d addr %h data %h start %h err %0d",
                  why, want.result_kind, want.write_address, want.write_data,
                  want.start_address, want.error_code);
         $display("   got kind %0d addr %h data %h start %h err %0d",
                  got.result_kind, got.write_address, got.write_data,
                  got.start_address, got.error_code);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         decoded_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.result_kind   = rsp_mon.result_kind;
            seen.write_address = rsp_mon.write_address;
            seen.write_data    = rsp_mon.write_data;
            seen.start_address = rsp_mon.start_address;
            seen.error_code    = rsp_mon.error_code;
            if (decoded_results.size() == 0) begin
               flag_result("result with nothing pending", '0, seen);
            end else begin
               oldest = decoded_results.pop_front();
               if (seen !== oldest) flag_result("result mismatch", oldest, seen);
            end
         end
         if (req_mon.valid && req_mon.ready) decode_char(req_mon.char_in);
      end
      pending_count = decoded_results.size();
   end

endmodule

### tb/hex_record_loader_tb.sv
`timescale 1ns / 1ps

module hex_record_loader_tb;
   import hrl_pkg::*;

   typedef enum logic [2:0] {
      GAP_NONE,
      GAP_SEND,
      GAP_RECV,
      GAP_HOLD,
      GAP_BOTH
   } gap_mode_type;

   localparam int CHAR_TARGET    = 750;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int GARBAGE_CHARS  = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   pending_count;

   gap_mode_type gap_mode = GAP_NONE;
   logic [7:0]   char_stream[$];
   logic [7:0]   payload[$];

   hrl_char_if req_if ();
   hrl_rsp_if  rsp_if ();

   hex_record_loader dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   hex_record_loader_checker decode_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] letter;
      if (n < 4'd10) return "0" + {4'd0, n};
      letter = $urandom_range(0, 1) ? "A" : "a";
      return letter + {4'd0, n} - 8'd10;
   endfunction

   function automatic bit is_hex_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      b = 8'($urandom);
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return b;
      endcase
   endfunction

   function automatic logic [15:0] data_addr();
      logic [15:0] a;
      a = 16'($urandom);
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFF0 + {12'd0, a[3:0]};
         default: return a;
      endcase
   endfunction

   task automatic add_byte(input logic [7:0] b);
      char_stream.push_back(hex_digit(b[7:4]));
      char_stream.push_back(hex_digit(b[3:0]));
   endtask

   task automatic add_record(input logic [7:0] count, input logic [15:0] addr,
                             input logic [7:0] rtype, input logic [7:0] skew);
      logic [7:0] csum;
      char_stream.push_back(CH_COLON);
      add_byte(count);
      add_byte(addr[15:8]);
      add_byte(addr[7:0]);
      add_byte(rtype);
      csum = count + addr[15:8] + addr[7:0] + rtype;
      foreach (payload[i]) begin
         add_byte(payload[i]);
         csum = csum + payload[i];
      end
      csum = 8'h00 - csum + skew;
      add_byte(csum);
      payload.delete();
   endtask

   task automatic add_typed_record(input logic [7:0] rtype, input logic [15:0] addr,
                                   input logic [7:0] skew);
      int         n;
      logic [7:0] count;
      if (rtype == REC_DATA) begin
         if ($urandom_range(0, 39) == 0) begin
            n = $urandom_range(0, 1) ? 255 : $urandom_range(17, 254);
         end else begin
            n = $urandom_range(0, 16);
         end
      end else if (rtype == REC_ESA || rtype == REC_ELA) begin
         n = 2;
      end else if (rtype == REC_SSA || rtype == REC_SLA) begin
         n = 4;
      end else begin
         n = 0;
      end
      if (rtype == REC_ELA && $urandom_range(0, 3) == 0) begin
         payload.push_back(8'hFF);
         payload.push_back(8'hFF);
      end else begin
         repeat (n) payload.push_back(pick_byte());
      end
      count = (rtype == REC_DATA) ? n[7:0] : pick_byte();
      add_record(count, addr, rtype, skew);
   endtask

   task automatic add_separator();
      case ($urandom_range(0, 9))
         5, 6: begin
            char_stream.push_back(CH_CR);
            char_stream.push_back(CH_LF);
         end
         7:       char_stream.push_back(CH_LF);
         8:       char_stream.push_back(CH_CR);
         9:       char_stream.push_back(CH_SUB);
         default: ;
      endcase
   endtask

   task automatic add_random_record();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         add_typed_record(8'(REC_DATA), data_addr(), 8'd0);
      end else if (r < 80) begin
         add_typed_record(8'(REC_ELA), 16'($urandom), 8'd0);
      end else if (r < 86) begin
         add_typed_record(8'(REC_ESA), 16'd0, 8'd0);
      end else if (r < 93) begin
         add_typed_record(8'(REC_SSA), 16'd0, 8'd0);
      end else begin
         add_typed_record(8'(REC_SLA), 16'd0, 8'd0);
      end
      add_separator();
   endtask

   // The parser stops for good on any of these, so only one ends each run.
   task automatic add_terminal();
      logic [7:0] c;
      logic [7:0] t;
      case ($urandom_range(0, 6))
         0: add_typed_record(8'(REC_EOF), 16'($urandom), 8'd0);
         1: char_stream.push_back(CH_NUL);
         2: begin
            if ($urandom_range(0, 1)) begin
               c = 8'h26;
            end else begin
               do c = 8'($urandom); while (c == CH_NUL || c == CH_CR || c == CH_LF ||
                                           c == CH_SUB || c == CH_COLON);
            end
            char_stream.push_back(c);
         end
         3: begin
            char_stream.push_back(CH_COLON);
            repeat ($urandom_range(0, 11)) char_stream.push_back(hex_digit(4'($urandom)));
            if ($urandom_range(0, 3) == 0) begin
               c = CH_NUL;
            end else begin
               do c = 8'($urandom); while (is_hex_char(c));
            end
            char_stream.push_back(c);
         end
         4: add_typed_record(8'($urandom_range(6, 255)), 16'($urandom), 8'd0);
         5: begin
            case ($urandom_range(0, 2))
               0:       t = 8'(REC_ESA);
               1:       t = 8'(REC_SSA);
               default: t = 8'(REC_SLA);
            endcase
            add_typed_record(t, 16'($urandom_range(1, 65535)), 8'd0);
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       t = 8'(REC_DATA);
               1:       t = 8'(REC_ESA);
               2:       t = 8'(REC_SSA);
               3:       t = 8'(REC_ELA);
               default: t = 8'(REC_SLA);
            endcase
            add_typed_record(t, (t == REC_DATA || t == REC_ELA) ? data_addr() : 16'd0,
                             8'($urandom_range(1, 255)));
         end
      endcase
   endtask

   task automatic build_file();
      char_stream.push_back(CH_CR);
      char_stream.push_back(CH_LF);
      char_stream.push_back(CH_SUB);
      payload.push_back(8'hFF);
      payload.push_back(8'hFF);
      add_record(8'h02, 16'hFFFF, 8'(REC_ELA), 8'd0);
      payload.push_back(8'h00);
      add_record(8'h01, 16'hFFFF, 8'(REC_DATA), 8'd0);
      while (char_stream.size() < CHAR_TARGET) add_random_record();
      add_terminal();
      repeat (GARBAGE_CHARS) char_stream.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      int pos;
      req_if.valid   = 1'b0;
      req_if.char_in = 8'h00;
      build_file();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      pos = 0;
      while (pos < char_stream.size()) begin
         @(posedge clock);
         if (req_if.valid && req_if.ready) pos++;
         if (pos == char_stream.size()) begin
            req_if.valid <= 1'b0;
         end else begin
            gap_mode = gap_mode_type'(pos * 5 / char_stream.size());
            if (!req_if.valid || req_if.ready) begin
               if ((gap_mode == GAP_SEND && $urandom_range(0, 99) < 49) ||
                   (gap_mode == GAP_BOTH && $urandom_range(0, 99) < 15)) begin
                  req_if.valid <= 1'b0;
               end else begin
                  req_if.valid   <= 1'b1;
                  req_if.char_in <= char_stream[pos];
               end
            end
         end
      end
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : receiver
      bit held;
      held         = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (gap_mode == GAP_HOLD && !held) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (gap_mode == GAP_RECV) begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 49);
         end else if (gap_mode == GAP_BOTH) begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 15);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

endmodule
